FILE: rtl/watermark_lru_cache_policy_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU cache policy block
// Wrappers that compile to concurrent assertions in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef WATERMARK_LRU_CACHE_POLICY_ASSERT_SVH
`define WATERMARK_LRU_CACHE_POLICY_ASSERT_SVH

`ifndef SYNTHESIS
`define WLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wlc assertion failed");
`define WLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlc assertion failed");
`else
`define WLC_ASSERT(lbl, clk, rst_n, prop)
`define WLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/wlc_pkg.sv
// ----------------------------------------------------------------------------
// wlc_pkg
// Shared widths, codes and helpers of the LRU cache policy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wlc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 16;

    localparam int MODE_W     = 2;
    localparam int KEY_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int OBJB_W     = 40;
    localparam int TOTB_W     = 46;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 4;
    localparam int SLOT_W     = 6;
    localparam int PIN_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 46;

    localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_HIT      = 4'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 4'd1;
    localparam logic [STAT_W-1:0] ST_STALE    = 4'd2;
    localparam logic [STAT_W-1:0] ST_INSERTED = 4'd3;
    localparam logic [STAT_W-1:0] ST_REFUSED  = 4'd4;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 4'd5;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 4'd6;
    localparam logic [STAT_W-1:0] ST_PINNED   = 4'd7;
    localparam logic [STAT_W-1:0] ST_RELEASED = 4'd8;
    localparam logic [STAT_W-1:0] ST_REL_IGN  = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILES = 1'b1;

    // one restoring step of a divide by five: {quotient bit, new remainder}
    function automatic logic [3:0] div5_step(input logic [2:0] rem, input logic bit_in);
        logic [3:0] t;
        t = {rem, bit_in};
        if (t >= 4'd5) begin
            div5_step = {1'b1, 3'(t - 4'd5)};
        end else begin
            div5_step = {1'b0, t[2:0]};
        end
    endfunction

endpackage

FILE: rtl/wlc_req_if.sv
// ----------------------------------------------------------------------------
// wlc_req_if
// Request channel: one cache request item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wlc_req_if;
    import wlc_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    obj_key;
    logic [STAMP_W-1:0]  now_stamp;
    logic [STAMP_W-1:0]  source_time;
    logic [OBJB_W-1:0]   obj_bytes;
    logic                pin_request;

    modport source (output valid, mode, obj_key, now_stamp, source_time, obj_bytes,
                    pin_request, input ready);
    modport sink   (input valid, mode, obj_key, now_stamp, source_time, obj_bytes,
                    pin_request, output ready);
endinterface

FILE: rtl/wlc_rsp_if.sv
// ----------------------------------------------------------------------------
// wlc_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wlc_rsp_if;
    import wlc_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  hit_slot;
    logic [CNT_W-1:0]   evicted_count;
    logic [TOTB_W-1:0]  bytes_in_use;
    logic [CNT_W-1:0]   entries_in_use;

    modport source (output valid, status, hit_slot, evicted_count, bytes_in_use,
                    entries_in_use, input ready);
    modport sink   (input valid, status, hit_slot, evicted_count, bytes_in_use,
                    entries_in_use, output ready);
endinterface

FILE: rtl/wlc_ram.sv
// ----------------------------------------------------------------------------
// wlc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wlc_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: rtl/watermark_lru_cache_policy.sv
// ----------------------------------------------------------------------------
// watermark_lru_cache_policy
// LRU object cache policy with high/low watermark eviction.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request item (lookup, insert, release pin, remove);
//   o_rsp returns exactly one result item per request. Both are valid/ready.
//   Limits are set through i_cfg_we/i_cfg_idx/i_cfg_data while the block is
//   idle: index 0 max_bytes, index 1 max_files.
//   One item is worked at a time; i_req.ready is high only in idle with the
//   result register empty. Lookup, release and remove take one key scan of
//   the slot table to the result; insert takes the key scan and a watermark
//   check, then an oldest-entry scan and another check for each eviction,
//   then a free slot scan over the valid bits. The scans are bound by the
//   single read port of the slot table, which is walked one slot a cycle for
//   key match and for the oldest-entry search.
//   The result is held in a register until o_rsp.ready; no new item is taken
//   meanwhile. Reset clears the valid bits, totals and limits at once; no
//   clearing pass runs. Table contents need no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "watermark_lru_cache_policy_assert.svh"

module watermark_lru_cache_policy #(
    parameter int TABLE_ENTRIES = wlc_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = wlc_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wlc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wlc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wlc_req_if.sink                        i_req,
    wlc_rsp_if.source                      o_rsp
);
    import wlc_pkg::*;

    // widths
    localparam int IW  = $clog2(TABLE_ENTRIES);     // slot index
    localparam int SCW = IW + 1;                    // scan counter, holds N
    localparam int CW  = $clog2(TABLE_ENTRIES + 1); // entry count
    localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int BX_W = TOTB_W + 3;               // bytes * 5
    localparam int CX_W = CW + 3;                   // count * 5

    // table word layout: {key, stamp, bytes, source time, pins}
    localparam int PIN_LO  = 0;
    localparam int SRC_LO  = PIN_LO + PIN_W;
    localparam int BYT_LO  = SRC_LO + STAMP_W;
    localparam int STP_LO  = BYT_LO + OBJB_W;
    localparam int KEY_LO  = STP_LO + STAMP_W;
    localparam int WORD_W  = KEY_LO + KW;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OLD   = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;

    localparam logic [SCW-1:0] SCAN_END = SCW'(TABLE_ENTRIES);

    // control
    logic [2:0]               r_state;
    logic [SCW-1:0]           r_cnt;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TOTB_W-1:0]        r_tot_b;
    logic [CW-1:0]            r_tot_n;
    logic [TOTB_W-1:0]        r_max_b;
    logic [CNT_W-1:0]         r_max_f;
    logic                     r_found;
    logic                     r_have;
    logic                     r_first;
    logic [CW-1:0]            r_evict;
    logic                     r_ovalid;

    // payload
    logic [MODE_W-1:0]  r_mode;
    logic [KW-1:0]      r_key;
    logic [STAMP_W-1:0] r_now;
    logic [STAMP_W-1:0] r_src;
    logic [OBJB_W-1:0]  r_objb;
    logic               r_pin;
    logic [IW-1:0]      r_s;
    logic [WORD_W-1:0]  r_s_word;
    logic [IW-1:0]      r_best;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [OBJB_W-1:0]  r_best_bytes;
    logic [STAT_W-1:0]  r_status;
    logic [SLOT_W-1:0]  r_hslot;
    logic [CNT_W-1:0]   r_oevict;

    // table RAM
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    wlc_ram #(.W(WORD_W), .D(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // slot under evaluation: the one read in the previous cycle
    logic [SCW-1:0] cnt_m1;
    logic [IW-1:0]  ev_slot;
    logic           ev_on;
    logic           slot_v;
    assign cnt_m1  = r_cnt - 1'b1;
    assign ev_slot = cnt_m1[IW-1:0];
    assign ev_on   = (r_cnt != '0);
    assign slot_v  = r_valid[ev_slot];

    logic scan_end;
    assign scan_end = (r_cnt == SCAN_END);

    // key match, merged with this cycle's slot at the end of the scan
    logic              cur_match;
    logic              f_hit;
    logic [IW-1:0]     f_slot;
    logic [WORD_W-1:0] f_word;
    logic [PIN_W-1:0]  f_pins;
    logic [OBJB_W-1:0] f_bytes;
    logic              f_stale;
    assign cur_match = ev_on && slot_v && (ram_rdata[KEY_LO +: KW] == r_key);
    assign f_hit     = r_found | cur_match;
    assign f_slot    = r_found ? r_s : ev_slot;
    assign f_word    = r_found ? r_s_word : ram_rdata;
    assign f_pins    = f_word[PIN_LO +: PIN_W];
    assign f_bytes   = f_word[BYT_LO +: OBJB_W];
    assign f_stale   = r_src > f_word[SRC_LO +: STAMP_W];

    // oldest unpinned candidate, merged the same way
    logic               cand;
    logic               o_have;
    logic [IW-1:0]      o_slot;
    logic [STAMP_W-1:0] o_stamp;
    logic [OBJB_W-1:0]  o_bytes;
    assign cand = ev_on && slot_v && (ram_rdata[PIN_LO +: PIN_W] == '0)
                  && (!r_have || (ram_rdata[STP_LO +: STAMP_W] < r_best_stamp));
    assign o_have  = r_have | cand;
    assign o_slot  = cand ? ev_slot : r_best;
    assign o_stamp = cand ? ram_rdata[STP_LO +: STAMP_W] : r_best_stamp;
    assign o_bytes = cand ? ram_rdata[BYT_LO +: OBJB_W] : r_best_bytes;

    // limits and watermarks
    // low mark is floor(limit*4/5); total <= that holds exactly when
    // 5*total <= 4*limit, so no divide is needed
    logic [CW-1:0]   lim;
    logic            byte_over;
    logic            cnt_over;
    logic            below_low;
    logic [BX_W-1:0] tot_b_x5;
    logic [BX_W-1:0] max_b_x4;
    logic [CX_W-1:0] tot_n_x5;
    logic [CX_W-1:0] lim_x4;
    always_comb begin
        if (r_max_f != '0 && int'(r_max_f) <= TABLE_ENTRIES) begin
            lim = CW'(r_max_f);
        end else begin
            lim = CW'(TABLE_ENTRIES);
        end
    end
    assign tot_b_x5  = {1'b0, r_tot_b, 2'b00} + {3'b000, r_tot_b};
    assign max_b_x4  = {1'b0, r_max_b, 2'b00};
    assign tot_n_x5  = {1'b0, r_tot_n, 2'b00} + {3'b000, r_tot_n};
    assign lim_x4    = {1'b0, lim, 2'b00};
    assign byte_over = (r_max_b != '0) && (r_tot_b >= r_max_b);
    assign cnt_over  = (r_tot_n >= lim);
    assign below_low = ((r_max_b == '0) || (tot_b_x5 <= max_b_x4))
                       && (tot_n_x5 <= lim_x4);

    // free slot scan walks the valid bits
    logic [IW-1:0] fr_slot;
    logic          fr_empty;
    assign fr_slot  = r_cnt[IW-1:0];
    assign fr_empty = !r_valid[fr_slot];

    logic find_done;
    assign find_done = (r_state == S_FIND) && scan_end;

    // table writes: lookup/release update in place, insert writes a new word
    logic [PIN_W-1:0] upd_pins;
    always_comb begin
        upd_pins  = f_pins;
        ram_we    = 1'b0;
        ram_waddr = f_slot;
        ram_wdata = f_word;
        if (find_done && f_hit) begin
            if (r_mode == MODE_LOOKUP) begin
                if (!f_stale && r_pin && f_pins != PIN_MAX) begin
                    upd_pins = f_pins + 1'b1;
                end
                ram_we = 1'b1;
                ram_wdata[STP_LO +: STAMP_W] = r_now;
                ram_wdata[PIN_LO +: PIN_W]   = upd_pins;
            end else if (r_mode == MODE_RELEASE && f_pins != '0) begin
                upd_pins = f_pins - 1'b1;
                ram_we   = 1'b1;
                ram_wdata[PIN_LO +: PIN_W] = upd_pins;
            end
        end else if (r_state == S_FREE && fr_empty) begin
            ram_we    = 1'b1;
            ram_waddr = fr_slot;
            ram_wdata = {r_key, r_now, r_objb, r_src, {PIN_W{1'b0}}};
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_status;
    assign o_rsp.hit_slot       = r_hslot;
    assign o_rsp.evicted_count  = r_oevict;
    assign o_rsp.bytes_in_use   = r_tot_b;
    assign o_rsp.entries_in_use = CNT_W'(r_tot_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_valid  <= '0;
            r_tot_b  <= '0;
            r_tot_n  <= '0;
            r_max_b  <= '0;
            r_max_f  <= '0;
            r_found  <= 1'b0;
            r_have   <= 1'b0;
            r_first  <= 1'b0;
            r_evict  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_BYTES: r_max_b <= i_cfg_data;
                    CFG_MAX_FILES: r_max_f <= i_cfg_data[CNT_W-1:0];
                    default:       r_max_f <= r_max_f;
                endcase
            end

            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_mode  <= i_req.mode;
                        r_key   <= i_req.obj_key[KW-1:0];
                        r_now   <= i_req.now_stamp;
                        r_src   <= i_req.source_time;
                        r_objb  <= i_req.obj_bytes;
                        r_pin   <= i_req.pin_request;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_evict <= '0;
                        r_state <= S_FIND;
                    end
                end

                S_FIND: begin
                    if (cur_match && !r_found) begin
                        r_found  <= 1'b1;
                        r_s      <= ev_slot;
                        r_s_word <= ram_rdata;
                    end
                    if (!scan_end) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_hslot  <= '0;
                        r_oevict <= '0;
                        unique case (r_mode)
                            MODE_LOOKUP: begin
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                                if (!f_hit) begin
                                    r_status <= ST_MISS;
                                end else if (f_stale) begin
                                    r_status <= ST_STALE;
                                end else begin
                                    r_status <= ST_HIT;
                                    r_hslot  <= SLOT_W'(f_slot);
                                end
                            end
                            MODE_INSERT: begin
                                // same key goes first, before any watermark check
                                if (f_hit) begin
                                    r_valid[f_slot] <= 1'b0;
                                    r_tot_b <= r_tot_b - TOTB_W'(f_bytes);
                                    if (r_tot_n != '0) begin
                                        r_tot_n <= r_tot_n - 1'b1;
                                    end
                                end
                                r_first <= 1'b1;
                                r_state <= S_CHECK;
                            end
                            MODE_RELEASE: begin
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                                r_status <= (f_hit && f_pins != '0) ? ST_RELEASED
                                                                    : ST_REL_IGN;
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                                if (!f_hit) begin
                                    r_status <= ST_NOTFOUND;
                                end else if (f_pins != '0) begin
                                    r_status <= ST_PINNED;
                                end else begin
                                    r_status <= ST_REMOVED;
                                    r_valid[f_slot] <= 1'b0;
                                    r_tot_b <= r_tot_b - TOTB_W'(f_bytes);
                                    if (r_tot_n != '0) begin
                                        r_tot_n <= r_tot_n - 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end

                S_CHECK: begin
                    r_first <= 1'b0;
                    r_cnt   <= '0;
                    r_have  <= 1'b0;
                    if ((r_first && !byte_over && !cnt_over) || below_low) begin
                        r_state <= S_FREE;
                    end else begin
                        r_state <= S_OLD;
                    end
                end

                S_OLD: begin
                    if (cand) begin
                        r_have       <= 1'b1;
                        r_best       <= ev_slot;
                        r_best_stamp <= o_stamp;
                        r_best_bytes <= o_bytes;
                    end
                    if (!scan_end) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!o_have) begin
                        // everything left is pinned
                        r_status <= ST_REFUSED;
                        r_hslot  <= '0;
                        r_oevict <= CNT_W'(r_evict);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_valid[o_slot] <= 1'b0;
                        r_tot_b <= r_tot_b - TOTB_W'(o_bytes);
                        if (r_tot_n != '0) begin
                            r_tot_n <= r_tot_n - 1'b1;
                        end
                        r_evict <= r_evict + 1'b1;
                        r_state <= S_CHECK;
                    end
                end

                S_FREE: begin
                    if (fr_empty) begin
                        r_valid[fr_slot] <= 1'b1;
                        r_tot_b  <= r_tot_b + TOTB_W'(r_objb);
                        r_tot_n  <= r_tot_n + 1'b1;
                        r_status <= ST_INSERTED;
                        r_hslot  <= SLOT_W'(fr_slot);
                        r_oevict <= CNT_W'(r_evict);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_cnt == SCAN_END - 1'b1) begin
                        r_status <= ST_REFUSED;
                        r_hslot  <= '0;
                        r_oevict <= CNT_W'(r_evict);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // entry count tracks the valid bits through every free and insert
    `WLC_ASSERT(a_count_matches_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_tot_n))
    // an accepted item always starts with the key scan
    `WLC_ASSERT(a_accept_starts_find, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> (r_state == S_FIND))
    // a result appears only as the sequencer returns to idle
    `WLC_ASSERT_IMP(a_result_at_idle, i_clk, i_rst_n, $rose(r_ovalid), r_state == S_IDLE)
    // never more entries than slots
    `WLC_ASSERT(a_count_bound, i_clk, i_rst_n, int'(r_tot_n) <= TABLE_ENTRIES)

endmodule
